/* rtl/core/idl_pkg.sv */
// Shared widths, ring geometry, register indexes and reset values for the interpolating delay line.
package idl_pkg;

	// Ring geometry
	localparam int RING_DEPTH    = 4096;
	localparam int FRACTION_BITS = 16;

	// Fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int DELAY_W  = 28;
	localparam int SHIFT_W  = 4;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_DELAY = 2'd0,
		REG_GLIDE_SHIFT  = 2'd1
	} cfg_reg_t;

	// Glide shift after reset
	localparam logic [SHIFT_W-1:0] GLIDE_SHIFT_RST = 4'd13;

endpackage

/* rtl/core/interpolating_delay_line.sv */
// Fractional delay line with gliding delay and linear interpolation (top level).
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------
//  in      | in_valid / in_stall  | in_sample   (16 b, signed Q1.15)
//  out     | out_valid / out_stall| out_sample  (16 b, signed Q1.15)
//  cfg     | cfg_valid / cfg_ready| cfg_index (2 b), cfg_data (28 b)
//
// One sample in and one out per cycle unless clearing or out_stall holds it;
// a sample passes input stage, memory read, product and output register
// before out_valid rises. After reset the sample ring is cleared, one entry
// a cycle, over all RING_DEPTH entries; in_stall is high during that pass.
// cfg_ready is always high. While out_valid and out_stall are both high
// the whole pipeline holds and in_stall is raised in the same cycle.
module interpolating_delay_line
	import idl_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	// input samples
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	// output samples
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] out_sample,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [DELAY_W-1:0]         cfg_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int FB = FRACTION_BITS;
	localparam int PW = SAMPLE_W + FB + 2;
	localparam logic [63:0] DELAY_MAX  = 64'(RING_DEPTH - 2) << FB;
	localparam logic [63:0] DELAY_HALF = 64'(RING_DEPTH / 2) << FB;
	localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

	// Configuration registers
	logic [DELAY_W-1:0] target_q;
	logic [SHIFT_W-1:0] shift_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= DELAY_W'(DELAY_HALF);
			shift_q  <= GLIDE_SHIFT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TARGET_DELAY: begin
					if (64'(cfg_data) <= DELAY_MAX)
						target_q <= cfg_data;
				end
				REG_GLIDE_SHIFT: shift_q <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clearing pass over the ring after reset
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR)
				clr_busy_q <= 1'b0;
		end
	end

	// Pipeline advance and input handshake
	logic adv;
	logic in_acc;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = clr_busy_q || !adv;
	assign in_acc   = in_valid && !in_stall;

	// Current delay and write position
	logic [DELAY_W-1:0] delay_q;
	logic [AW-1:0]      wr_pos_q;

	// Delay glide: floor of the difference over 2^shift, then clamp
	logic signed [DELAY_W:0] glide_diff;
	logic signed [DELAY_W:0] glide_step;
	logic signed [DELAY_W:0] glide_sum;
	logic [DELAY_W-1:0]      delay_next;

	always_comb begin
		glide_diff = $signed({1'b0, target_q}) - $signed({1'b0, delay_q});
		glide_step = glide_diff >>> shift_q;
		glide_sum  = $signed({1'b0, delay_q}) + glide_step;
		if (64'(glide_sum[DELAY_W-1:0]) > DELAY_MAX)
			delay_next = DELAY_W'(DELAY_MAX);
		else
			delay_next = glide_sum[DELAY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_W'(DELAY_HALF);
			wr_pos_q <= '0;
		end else if (in_acc) begin
			delay_q  <= delay_next;
			wr_pos_q <= wr_pos_q + 1'b1;
		end
	end

	// Stage 1: accepted sample, its write slot and the new delay
	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [AW-1:0]              wp_s1;
	logic [DELAY_W-1:0]         delay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_acc;
	end

	always_ff @(posedge clk) begin
		if (adv && in_acc) begin
			sample_s1 <= in_sample;
			wp_s1     <= wr_pos_q;
			delay_s1  <= delay_next;
		end
	end

	// Read addresses for integer delay i and i+1
	logic [AW-1:0] ipart;
	logic [AW-1:0] rd_lo;
	logic [AW-1:0] rd_hi;

	always_comb begin
		ipart = delay_s1[FB +: AW];
		rd_lo = wp_s1 - ipart;
		rd_hi = rd_lo - 1'b1;
	end

	// Sample ring: one write port, two registered reads
	logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic signed [SAMPLE_W-1:0] mem_wdata;

	assign mem_we    = clr_busy_q || (adv && valid_s1);
	assign mem_waddr = clr_busy_q ? clr_addr_q : wp_s1;
	assign mem_wdata = clr_busy_q ? '0 : sample_s1;

	logic signed [SAMPLE_W-1:0] raw_lo_s2;
	logic signed [SAMPLE_W-1:0] raw_hi_s2;

	always_ff @(posedge clk) begin
		if (mem_we)
			ring_mem[mem_waddr] <= mem_wdata;
		if (adv) begin
			raw_lo_s2 <= ring_mem[rd_lo];
			raw_hi_s2 <= ring_mem[rd_hi];
		end
	end

	// Stage 2: read data, bypass of the sample written in the same cycle
	logic                       valid_s2;
	logic                       fwd_lo_s2;
	logic                       fwd_hi_s2;
	logic signed [SAMPLE_W-1:0] fwd_sample_s2;
	logic [FB-1:0]              frac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fwd_lo_s2     <= (rd_lo == wp_s1);
			fwd_hi_s2     <= (rd_hi == wp_s1);
			fwd_sample_s2 <= sample_s1;
			frac_s2       <= delay_s1[FB-1:0];
		end
	end

	// lower + (upper - lower) * f, multiply here
	logic signed [SAMPLE_W-1:0] lower;
	logic signed [SAMPLE_W-1:0] upper;
	logic signed [SAMPLE_W:0]   slope;
	logic signed [PW-1:0]       prod;

	always_comb begin
		lower = fwd_lo_s2 ? fwd_sample_s2 : raw_lo_s2;
		upper = fwd_hi_s2 ? fwd_sample_s2 : raw_hi_s2;
		slope = (SAMPLE_W+1)'(upper) - (SAMPLE_W+1)'(lower);
		prod  = PW'(slope) * PW'($signed({1'b0, frac_s2}));
	end

	// Stage 3: product and base sample
	logic                       valid_s3;
	logic signed [PW-1:0]       prod_s3;
	logic signed [SAMPLE_W-1:0] lower_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3  <= prod;
			lower_s3 <= lower;
		end
	end

	// Sum and divide by 2^FB, rounding toward zero
	logic signed [PW-1:0] num;
	logic signed [PW-1:0] quot;
	logic signed [PW-1:0] quot_rz;

	always_comb begin
		num  = (PW'(lower_s3) <<< FB) + prod_s3;
		quot = num >>> FB;
		if (num[PW-1] && (num[FB-1:0] != '0))
			quot_rz = quot + PW'(1);
		else
			quot_rz = quot;
	end

	// Output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_sample_q <= quot_rz[SAMPLE_W-1:0];
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

endmodule
